[sv/psch_pkg.sv]
// Shared codes and widths for the periodic task scheduler.
package psch_pkg;

   localparam int DEF_NUM_SLOTS = 16;
   localparam int MAX_RES       = 16;

   localparam int REQ_W   = 3;
   localparam int ID_W    = 4;
   localparam int TICK_W  = 32;
   localparam int STAT_W  = 2;
   localparam int MODE_W  = 2;
   localparam int COUNT_W = $clog2(MAX_RES + 1);

   // request codes
   localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_SUSPEND = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RESUME  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_TICK    = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SCAN    = 3'd6;
   localparam logic [REQ_W-1:0] REQ_DONE    = 3'd7;

   // slot modes
   localparam logic [MODE_W-1:0] MODE_SUSP  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RUN   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TOUT  = 2'd3;

   // result status
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_REJECT  = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOTHING = 2'd2;

endpackage

[sv/periodic_task_scheduler.sv]
// Periodic task scheduler: slot table, tick count and request sequencer.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  type, slot id, period, limit, handler flag
//   rsp_     out        rsp_valid / rsp_ready  status, slot, state, timeout flag, last flag
//
// One request is taken at a time; req_ready is high only while the sequencer is idle.
// Tick, delete, suspend, resume, query and invalid adds are answered by one execute state;
// done from its own; both hold on an output stall. Add walks valid bits one slot a cycle.
// Scan visits one slot a cycle through the shared elapsed-time compare unless an output
// stall holds a due slot. Reset (synchronous) clears valid bits, modes and ticks; the
// slot RAMs are not cleared: add and dispatch write each word before it is read.
module periodic_task_scheduler #(
   parameter int NUM_SLOTS = psch_pkg::DEF_NUM_SLOTS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [psch_pkg::REQ_W-1:0]   req_type,
   input  logic [psch_pkg::ID_W-1:0]    req_slot_id,
   input  logic [psch_pkg::TICK_W-1:0]  req_period_ticks,
   input  logic [psch_pkg::TICK_W-1:0]  req_limit_ticks,
   input  logic                         req_has_handler,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [psch_pkg::STAT_W-1:0]  rsp_status,
   output logic [psch_pkg::ID_W-1:0]    rsp_result_slot,
   output logic [psch_pkg::MODE_W-1:0]  rsp_slot_state,
   output logic                         rsp_timeout_hit,
   output logic                         rsp_last_of_run
);
   import psch_pkg::*;

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_FIND = 3'd2;
   localparam logic [2:0] S_DONE = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_END  = 3'd5;

   // sequencer and request hold
   logic [2:0]          state_ff, state_in;
   logic [REQ_W-1:0]    type_ff;
   logic [ID_W-1:0]     id_ff;
   logic [TICK_W-1:0]   period_ff, limit_ff;
   logic                handler_ff;
   logic [SW-1:0]       idx_ff, idx_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                pend_ff, pend_in;
   logic [SW-1:0]       pend_slot_ff, pend_slot_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;

   // per-slot control state
   logic                valid_ff [NUM_SLOTS];
   logic                valid_in [NUM_SLOTS];
   logic [MODE_W-1:0]   mode_ff  [NUM_SLOTS];
   logic [MODE_W-1:0]   mode_in  [NUM_SLOTS];

   // output register
   logic                rsp_valid_ff;
   logic [STAT_W-1:0]   status_ff;
   logic [ID_W-1:0]     slot_ff;
   logic [MODE_W-1:0]   smode_ff;
   logic                hit_ff, last_ff;

   logic                out_push;
   logic [STAT_W-1:0]   out_status;
   logic [ID_W-1:0]     out_slot;
   logic [MODE_W-1:0]   out_mode;
   logic                out_hit, out_last;
   logic                out_free;

   // RAM ports
   logic [SW-1:0]       rd_addr, wr_addr;
   logic                cfg_we, run_we, start_we;
   logic [TICK_W-1:0]   period_rd, limit_rd, run_rd, start_rd;

   logic                accept;
   logic [SW-1:0]       id_idx, idx_next;
   logic                id_ok, slot_due, advance;
   logic [TICK_W-1:0]   elapsed_run, elapsed_start;

   psch_ram #(.WIDTH(TICK_W), .DEPTH(NUM_SLOTS)) u_period_ram (
      .clock(clock), .wr_en(cfg_we), .wr_addr(wr_addr), .wr_data(period_ff),
      .rd_addr(rd_addr), .rd_data(period_rd)
   );

   psch_ram #(.WIDTH(TICK_W), .DEPTH(NUM_SLOTS)) u_limit_ram (
      .clock(clock), .wr_en(cfg_we), .wr_addr(wr_addr), .wr_data(limit_ff),
      .rd_addr(rd_addr), .rd_data(limit_rd)
   );

   psch_ram #(.WIDTH(TICK_W), .DEPTH(NUM_SLOTS)) u_last_run_ram (
      .clock(clock), .wr_en(run_we), .wr_addr(wr_addr), .wr_data(tick_ff),
      .rd_addr(rd_addr), .rd_data(run_rd)
   );

   psch_ram #(.WIDTH(TICK_W), .DEPTH(NUM_SLOTS)) u_start_ram (
      .clock(clock), .wr_en(start_we), .wr_addr(wr_addr), .wr_data(tick_ff),
      .rd_addr(rd_addr), .rd_data(start_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   assign id_idx   = SW'(id_ff);
   assign idx_next = idx_ff + 1'b1;
   // out-of-range ids index the slot arrays truncated; the range check gates the result
   assign id_ok    = (32'(id_ff) < 32'(NUM_SLOTS)) && valid_ff[id_idx];

   // the shared elapsed-time compare: wrapping difference against a stored interval
   assign elapsed_run   = tick_ff - run_rd;
   assign elapsed_start = tick_ff - start_rd;
   assign slot_due      = valid_ff[idx_ff] && (mode_ff[idx_ff] == MODE_READY) &&
                          (elapsed_run >= period_rd);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      tick_in      = tick_ff;
      valid_in     = valid_ff;
      mode_in      = mode_ff;
      out_push     = 1'b0;
      out_status   = ST_OK;
      out_slot     = '0;
      out_mode     = MODE_SUSP;
      out_hit      = 1'b0;
      out_last     = 1'b0;
      cfg_we       = 1'b0;
      run_we       = 1'b0;
      start_we     = 1'b0;
      wr_addr      = idx_ff;
      advance      = 1'b0;
      rd_addr      = idx_ff;

      case (state_ff)
         S_IDLE: begin
            // point the RAMs at what the next state will read
            rd_addr = (req_type == REQ_DONE) ? SW'(req_slot_id) : '0;
            if (accept) begin
               idx_in   = '0;
               count_in = '0;
               pend_in  = 1'b0;
               case (req_type)
                  REQ_ADD: begin
                     if (req_has_handler && (req_period_ticks != '0)) begin
                        state_in = S_FIND;
                     end else begin
                        state_in = S_EXEC;
                     end
                  end
                  REQ_DONE: state_in = S_DONE;
                  REQ_SCAN: state_in = S_SCAN;
                  default:  state_in = S_EXEC;
               endcase
            end
         end

         S_EXEC: begin
            wr_addr = id_idx;
            if (out_free) begin
               out_push = 1'b1;
               state_in = S_IDLE;
               case (type_ff)
                  REQ_TICK: begin
                     tick_in = tick_ff + 1'b1;
                  end
                  REQ_DELETE: begin
                     if (id_ok) begin
                        valid_in[id_idx] = 1'b0;
                     end else begin
                        out_status = ST_REJECT;
                     end
                  end
                  REQ_SUSPEND: begin
                     if (id_ok) begin
                        mode_in[id_idx] = MODE_SUSP;
                        out_mode        = MODE_SUSP;
                     end else begin
                        out_status = ST_REJECT;
                     end
                  end
                  REQ_RESUME: begin
                     if (id_ok) begin
                        mode_in[id_idx] = MODE_READY;
                        run_we          = 1'b1;
                        out_mode        = MODE_READY;
                     end else begin
                        out_status = ST_REJECT;
                     end
                  end
                  REQ_QUERY: begin
                     if (id_ok) begin
                        out_mode = mode_ff[id_idx];
                     end else begin
                        out_status = ST_REJECT;
                     end
                  end
                  default: begin
                     // an add that fails its argument checks
                     out_status = ST_REJECT;
                  end
               endcase
            end
         end

         S_FIND: begin
            // walk to the lowest free slot
            if (!valid_ff[idx_ff]) begin
               if (out_free) begin
                  cfg_we           = 1'b1;
                  run_we           = 1'b1;
                  valid_in[idx_ff] = 1'b1;
                  mode_in[idx_ff]  = MODE_READY;
                  out_push         = 1'b1;
                  out_slot         = ID_W'(idx_ff);
                  out_mode         = MODE_READY;
                  state_in         = S_IDLE;
               end
            end else if (idx_ff == LAST_SLOT) begin
               if (out_free) begin
                  out_push   = 1'b1;
                  out_status = ST_REJECT;
                  state_in   = S_IDLE;
               end
            end else begin
               idx_in = idx_next;
            end
         end

         S_DONE: begin
            rd_addr = id_idx;
            if (out_free) begin
               out_push = 1'b1;
               state_in = S_IDLE;
               if (!id_ok) begin
                  out_status = ST_REJECT;
               end else if (mode_ff[id_idx] != MODE_RUN) begin
                  out_status = ST_REJECT;
                  out_mode   = mode_ff[id_idx];
               end else if ((limit_rd != '0) && (elapsed_start >= limit_rd)) begin
                  mode_in[id_idx] = MODE_TOUT;
                  out_slot        = id_ff;
                  out_mode        = MODE_TOUT;
                  out_hit         = 1'b1;
               end else begin
                  mode_in[id_idx] = MODE_READY;
                  out_slot        = id_ff;
                  out_mode        = MODE_READY;
               end
            end
         end

         S_SCAN: begin
            // evaluate slot idx_ff; hold one dispatch back so the last can be flagged
            if (slot_due) begin
               if (!pend_ff || out_free) begin
                  if (pend_ff) begin
                     out_push = 1'b1;
                     out_slot = ID_W'(pend_slot_ff);
                     out_mode = MODE_RUN;
                  end
                  run_we          = 1'b1;
                  start_we        = 1'b1;
                  mode_in[idx_ff] = MODE_RUN;
                  pend_in         = 1'b1;
                  pend_slot_in    = idx_ff;
                  count_in        = count_ff + 1'b1;
                  if ((count_ff == COUNT_W'(MAX_RES - 1)) || (idx_ff == LAST_SLOT)) begin
                     state_in = S_END;
                  end else begin
                     advance = 1'b1;
                  end
               end
            end else if (idx_ff == LAST_SLOT) begin
               state_in = S_END;
            end else begin
               advance = 1'b1;
            end
            if (advance) begin
               idx_in  = idx_next;
               rd_addr = idx_next;
            end
         end

         S_END: begin
            if (out_free) begin
               out_push = 1'b1;
               out_last = 1'b1;
               state_in = S_IDLE;
               if (pend_ff) begin
                  out_slot = ID_W'(pend_slot_ff);
                  out_mode = MODE_RUN;
               end else begin
                  out_status = ST_NOTHING;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
            mode_ff[i]  <= MODE_SUSP;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= out_push | (rsp_valid_ff & ~rsp_ready);
         valid_ff     <= valid_in;
         mode_ff      <= mode_in;
      end
   end

   // payload: hold the request, load the output register on each push
   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      if (accept) begin
         type_ff    <= req_type;
         id_ff      <= req_slot_id;
         period_ff  <= req_period_ticks;
         limit_ff   <= req_limit_ticks;
         handler_ff <= req_has_handler;
      end
      if (out_push) begin
         status_ff <= out_status;
         slot_ff   <= out_slot;
         smode_ff  <= out_mode;
         hit_ff    <= out_hit;
         last_ff   <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_slot = slot_ff;
   assign rsp_slot_state  = smode_ff;
   assign rsp_timeout_hit = hit_ff & handler_ff | hit_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[sv/psch_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module psch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/sv/psch_checker.sv]
// Transfer monitor, slot-table predictor and result comparison for the scheduler.
`timescale 1ns / 1ps

module psch_checker #(
   parameter int NUM_SLOTS = psch_pkg::DEF_NUM_SLOTS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [psch_pkg::REQ_W-1:0]   req_type,
   input  logic [psch_pkg::ID_W-1:0]    req_slot_id,
   input  logic [psch_pkg::TICK_W-1:0]  req_period_ticks,
   input  logic [psch_pkg::TICK_W-1:0]  req_limit_ticks,
   input  logic                         req_has_handler,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [psch_pkg::STAT_W-1:0]  rsp_status,
   input  logic [psch_pkg::ID_W-1:0]    rsp_result_slot,
   input  logic [psch_pkg::MODE_W-1:0]  rsp_slot_state,
   input  logic                         rsp_timeout_hit,
   input  logic                         rsp_last_of_run,
   output int                           fail_count,
   output int                           pending
);
   import psch_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   slot;
      logic [MODE_W-1:0] state;
      logic              hit;
      logic              last;
   } reply_type;

   logic              tbl_valid  [NUM_SLOTS];
   logic [MODE_W-1:0] tbl_mode   [NUM_SLOTS];
   logic [TICK_W-1:0] tbl_period [NUM_SLOTS];
   logic [TICK_W-1:0] tbl_last   [NUM_SLOTS];
   logic [TICK_W-1:0] tbl_limit  [NUM_SLOTS];
   logic [TICK_W-1:0] tbl_start  [NUM_SLOTS];
   logic [TICK_W-1:0] ticks;

   reply_type sched_reply_q[$];

   function automatic reply_type make_reply(logic [STAT_W-1:0] st, logic [ID_W-1:0] slot,
                                            logic [MODE_W-1:0] state, logic hit,
                                            logic last);
      reply_type r;
      r.status = st;
      r.slot   = slot;
      r.state  = state;
      r.hit    = hit;
      r.last   = last;
      return r;
   endfunction

   task automatic clear_table();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tbl_valid[i]  = 1'b0;
         tbl_mode[i]   = MODE_SUSP;
         tbl_period[i] = '0;
         tbl_last[i]   = '0;
         tbl_limit[i]  = '0;
         tbl_start[i]  = '0;
      end
      ticks = '0;
   endtask

   // Apply one request to the table and queue the replies it produces.
   task automatic advance_schedule(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                                   logic [TICK_W-1:0] period, logic [TICK_W-1:0] limit,
                                   logic handler);
      logic              known;
      logic              placed;
      logic              held;
      logic [TICK_W-1:0] elapsed;
      reply_type         prev;
      known  = (int'(id) < NUM_SLOTS) && tbl_valid[id];
      placed = 1'b0;
      held   = 1'b0;
      prev   = '0;
      case (kind)
         REQ_ADD: begin
            if (handler && period != 0) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (!placed && !tbl_valid[i]) begin
                     tbl_period[i] = period;
                     tbl_last[i]   = ticks;
                     tbl_limit[i]  = limit;
                     tbl_mode[i]   = MODE_READY;
                     tbl_valid[i]  = 1'b1;
                     placed        = 1'b1;
                     sched_reply_q.push_back(make_reply(ST_OK, ID_W'(i), MODE_READY, 0, 0));
                  end
               end
            end
            if (!placed)
               sched_reply_q.push_back(make_reply(ST_REJECT, 0, MODE_SUSP, 0, 0));
         end
         REQ_DELETE, REQ_SUSPEND, REQ_RESUME, REQ_QUERY: begin
            if (!known) begin
               sched_reply_q.push_back(make_reply(ST_REJECT, 0, MODE_SUSP, 0, 0));
            end else if (kind == REQ_DELETE) begin
               tbl_valid[id] = 1'b0;
               sched_reply_q.push_back(make_reply(ST_OK, 0, MODE_SUSP, 0, 0));
            end else begin
               if (kind == REQ_SUSPEND) begin
                  tbl_mode[id] = MODE_SUSP;
               end else if (kind == REQ_RESUME) begin
                  tbl_mode[id] = MODE_READY;
                  tbl_last[id] = ticks;
               end
               sched_reply_q.push_back(make_reply(ST_OK, 0, tbl_mode[id], 0, 0));
            end
         end
         REQ_TICK: begin
            ticks = ticks + 1'b1;
            sched_reply_q.push_back(make_reply(ST_OK, 0, MODE_SUSP, 0, 0));
         end
         REQ_SCAN: begin
            // hold each dispatch back one step so the final one can carry the last flag
            for (int i = 0; i < NUM_SLOTS; i++) begin
               elapsed = ticks - tbl_last[i];
               if (tbl_valid[i] && tbl_mode[i] == MODE_READY && elapsed >= tbl_period[i]) begin
                  tbl_mode[i]  = MODE_RUN;
                  tbl_start[i] = ticks;
                  tbl_last[i]  = ticks;
                  if (held)
                     sched_reply_q.push_back(prev);
                  prev = make_reply(ST_OK, ID_W'(i), MODE_RUN, 0, 0);
                  held = 1'b1;
               end
            end
            if (held) begin
               prev.last = 1'b1;
               sched_reply_q.push_back(prev);
            end else begin
               sched_reply_q.push_back(make_reply(ST_NOTHING, 0, MODE_SUSP, 0, 1));
            end
         end
         default: begin
            elapsed = ticks - tbl_start[id];
            if (!known) begin
               sched_reply_q.push_back(make_reply(ST_REJECT, 0, MODE_SUSP, 0, 0));
            end else if (tbl_mode[id] != MODE_RUN) begin
               sched_reply_q.push_back(make_reply(ST_REJECT, 0, tbl_mode[id], 0, 0));
            end else if (tbl_limit[id] != 0 && elapsed >= tbl_limit[id]) begin
               tbl_mode[id] = MODE_TOUT;
               sched_reply_q.push_back(make_reply(ST_OK, id, MODE_TOUT, 1, 0));
            end else begin
               tbl_mode[id] = MODE_READY;
               sched_reply_q.push_back(make_reply(ST_OK, id, MODE_READY, 0, 0));
            end
         end
      endcase
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         clear_table();
         sched_reply_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sched_reply_q.size() == 0) begin
               $error("result transfer with nothing expected (status %0d, slot %0d)",
                      rsp_status, rsp_result_slot);
               fail_count++;
            end else begin
               want = sched_reply_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("result_slot", 32'(want.slot), 32'(rsp_result_slot));
               check_field("slot_state", 32'(want.state), 32'(rsp_slot_state));
               check_field("timeout_hit", 32'(want.hit), 32'(rsp_timeout_hit));
               check_field("last_of_run", 32'(want.last), 32'(rsp_last_of_run));
            end
         end
         if (req_valid && req_ready)
            advance_schedule(req_type, req_slot_id, req_period_ticks, req_limit_ticks,
                             req_has_handler);
      end
      pending = sched_reply_q.size();
   end

endmodule

[tb/sv/tb_top.sv]
// Stimulus, clocking and verdict for the periodic task scheduler testbench.
`timescale 1ns / 1ps

module tb_top;
   import psch_pkg::*;

   localparam int NUM_SLOTS    = DEF_NUM_SLOTS;
   localparam int RANDOM_ITEMS = 365;
   localparam int CYCLE_LIMIT  = 1_200_000;
   localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 8;
   localparam int HOLD_CYCLES  = 500;
   localparam int HOLD_AFTER   = 180;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [REQ_W-1:0]    req_type;
   logic [ID_W-1:0]     req_slot_id;
   logic [TICK_W-1:0]   req_period_ticks;
   logic [TICK_W-1:0]   req_limit_ticks;
   logic                req_has_handler;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STAT_W-1:0]   rsp_status;
   logic [ID_W-1:0]     rsp_result_slot;
   logic [MODE_W-1:0]   rsp_slot_state;
   logic                rsp_timeout_hit;
   logic                rsp_last_of_run;

   int  fail_count;
   int  pending;
   int  cycles;
   int  items_sent;
   bit  quiet_sender;

   periodic_task_scheduler #(.NUM_SLOTS(NUM_SLOTS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_slot_id      (req_slot_id),
      .req_period_ticks (req_period_ticks),
      .req_limit_ticks  (req_limit_ticks),
      .req_has_handler  (req_has_handler),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_slot_state   (rsp_slot_state),
      .rsp_timeout_hit  (rsp_timeout_hit),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   psch_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_slot_id      (req_slot_id),
      .req_period_ticks (req_period_ticks),
      .req_limit_ticks  (req_limit_ticks),
      .req_has_handler  (req_has_handler),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_slot_state   (rsp_slot_state),
      .rsp_timeout_hit  (rsp_timeout_hit),
      .rsp_last_of_run  (rsp_last_of_run),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: count cycles and give up once the limit is passed.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // Mostly short gaps, a few long ones, none at all while the sender runs quiet.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_sender || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Small periods keep tasks falling due; the odd zero or full-width one widens coverage.
   function automatic logic [TICK_W-1:0] pick_period();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return $urandom_range(1, 6);
      if (roll < 88)
         return '0;
      return $urandom;
   endfunction

   function automatic logic [TICK_W-1:0] pick_limit();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return '0;
      if (roll < 90)
         return $urandom_range(1, 5);
      return $urandom;
   endfunction

   // Lower slots fill first, so lean the target slot towards them.
   function automatic logic [ID_W-1:0] pick_slot();
      if ($urandom_range(0, 99) < 70)
         return ID_W'($urandom_range(0, 7));
      return ID_W'($urandom_range(0, 15));
   endfunction

   // Present one request from a falling edge, hold it until the transfer, then idle a random gap, if any.
   task automatic offer(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                        logic [TICK_W-1:0] period, logic [TICK_W-1:0] limit,
                        logic handler);
      int gap;
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_slot_id      <= id;
      req_period_ticks <= period;
      req_limit_ticks  <= limit;
      req_has_handler  <= handler;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic offer_add(logic [TICK_W-1:0] period, logic [TICK_W-1:0] limit,
                            logic handler);
      offer(REQ_ADD, ID_W'($urandom_range(0, 15)), period, limit, handler);
   endtask

   task automatic offer_cmd(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id);
      offer(kind, id, $urandom, $urandom, 1'($urandom_range(0, 1)));
   endtask

   // Receiver: random bursts of ready and stall, one long hold-off to back the block up.
   initial begin
      bit held_off;
      int run;
      held_off  = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && items_sent >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            run = $urandom_range(0, 99);
            if (run < 10) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(50, 120)) @(negedge clock);
            end else if (run < 65) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(1, 4)) @(negedge clock);
            end else if (run < 95) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(negedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(15, 40)) @(negedge clock);
            end
         end
      end
   end

   initial begin
      int target;
      int roll;
      int count;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_QUERY;
      req_slot_id      = '0;
      req_period_ticks = '0;
      req_limit_ticks  = '0;
      req_has_handler  = 1'b0;
      items_sent       = 0;
      quiet_sender     = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table, rejected adds, field extremes, dispatch, done and timeout.
      offer_cmd(REQ_QUERY, 0);                    // query an empty slot
      offer_cmd(REQ_DONE, 15);                    // done on an empty slot
      offer_cmd(REQ_SCAN, 0);                     // nothing due
      offer_add(5, 3, 1'b0);                      // no handler
      offer_add('0, 3, 1'b1);                     // zero period
      offer_add(1, '0, 1'b1);                     // slot 0, no timeout
      offer_add('1, '1, 1'b1);                    // slot 1, never due
      offer_add(2, 1, 1'b1);                      // slot 2, short timeout
      offer_cmd(REQ_SCAN, 0);                     // none elapsed yet
      offer_cmd(REQ_TICK, 0);
      offer_cmd(REQ_SCAN, 0);                     // slot 0 alone
      offer_cmd(REQ_DONE, 0);                     // back to ready
      offer_cmd(REQ_TICK, 0);
      offer_cmd(REQ_SCAN, 0);                     // slots 0 and 2 in one run
      offer_cmd(REQ_TICK, 0);
      offer_cmd(REQ_DONE, 2);                     // timeout elapsed
      offer_cmd(REQ_DONE, 2);                     // done on a timed-out slot
      offer_cmd(REQ_DONE, 1);                     // done on a ready slot
      offer_cmd(REQ_SUSPEND, 1);
      offer_cmd(REQ_QUERY, 1);
      offer_cmd(REQ_RESUME, 1);
      offer_cmd(REQ_DELETE, 1);
      offer_cmd(REQ_QUERY, 1);                    // deleted slot reads invalid
      offer_cmd(REQ_SUSPEND, 9);
      offer_cmd(REQ_RESUME, 9);

      // Fill past capacity once so the full-table rejection is always reached.
      repeat (NUM_SLOTS + 1) offer_add($urandom_range(1, 4), pick_limit(), 1'b1);

      // Random: adds, scheduling rounds, commands and tick runs with random content, plus broken and noisy requests.
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         quiet_sender = ($urandom_range(0, 99) < 15);
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            count = $urandom_range(1, 18);
            repeat (count) offer_add(pick_period(), pick_limit(), $urandom_range(0, 9) != 0);
         end else if (roll < 50) begin
            repeat ($urandom_range(0, 3)) offer_cmd(REQ_TICK, 0);
            offer_cmd(REQ_SCAN, pick_slot());
            repeat ($urandom_range(1, 4)) offer_cmd(REQ_DONE, pick_slot());
         end else if (roll < 68) begin
            count = $urandom_range(1, 3);
            repeat (count)
               offer_cmd(REQ_W'($urandom_range(REQ_DELETE, REQ_QUERY)), pick_slot());
         end else if (roll < 82) begin
            repeat ($urandom_range(1, 6)) offer_cmd(REQ_TICK, pick_slot());
         end else begin
            repeat ($urandom_range(1, 3))
               offer(REQ_W'($urandom_range(0, 7)), ID_W'($urandom_range(0, 15)), $urandom,
                     $urandom, 1'($urandom_range(0, 1)));
         end
      end
      quiet_sender = 1'b0;
      req_valid <= 1'b0;

      // Drain every expected result, then let the block settle.
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[periodic_task_scheduler.f]
sv/psch_pkg.sv
sv/psch_ram.sv
sv/periodic_task_scheduler.sv
tb/sv/psch_checker.sv
tb/sv/tb_top.sv
